### hw/rtl/dmi_pkg.sv
// Shared types and constants of the disparity map inverter.
`default_nettype none

package dmi_pkg;

  // Fixed field widths.
  localparam int unsigned KIND_W = 2;
  localparam int unsigned SRC_W  = 12;
  localparam int unsigned DISP_W = 16;
  localparam int unsigned RD_W   = 8;
  localparam int unsigned VAL_W  = 13;
  localparam int unsigned CNT_W  = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned OFS_W  = 10;
  // Wide enough for any map dimension up to 4096 and for 4096 itself.
  localparam int unsigned DIM_W  = 13;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef logic [DIM_W-1:0] dim_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_LINES   = 3'd0,
    CFG_OUT_SAMPLES = 3'd1,
    CFG_FILL_EN     = 3'd2,
    CFG_SAMPLE_OFS  = 3'd3,
    CFG_LINE_OFS    = 3'd4
  } cfg_idx_e;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // Control states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CLEAR
  } state_e;

  // Effective configuration seen by the datapath.
  typedef struct packed {
    dim_t                     lines;
    dim_t                     samples;
    logic                     fill_en;
    logic signed [OFS_W-1:0]  sample_ofs;
    logic signed [OFS_W-1:0]  line_ofs;
  } cfg_t;

  // One word of the output map store: written mark plus both bands.
  typedef struct packed {
    logic             mark;
    logic [VAL_W-1:0] line_val;
    logic [VAL_W-1:0] sample_val;
  } entry_t;

  // Read request held while the store access is in flight.
  typedef struct packed {
    logic             in_map;
    logic             fill_en;
    logic [VAL_W-1:0] fill_line;
    logic [VAL_W-1:0] fill_sample;
  } rd_req_t;

endpackage

`default_nettype wire

### hw/rtl/dmi_if.sv
// Handshake interfaces for the input items and the result items.
`default_nettype none

interface dmi_in_if
  import dmi_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SRC_W-1:0]  src_line;
  logic [SRC_W-1:0]  src_sample;
  logic [DISP_W-1:0] line_disp;
  logic [DISP_W-1:0] sample_disp;
  logic [RD_W-1:0]   read_line;
  logic [RD_W-1:0]   read_sample;

  modport source (
    output valid, kind, src_line, src_sample, line_disp, sample_disp,
           read_line, read_sample,
    input  ready
  );
  modport sink (
    input  valid, kind, src_line, src_sample, line_disp, sample_disp,
           read_line, read_sample,
    output ready
  );
endinterface

interface dmi_out_if
  import dmi_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] line_value;
  logic [VAL_W-1:0] sample_value;
  logic [CNT_W-1:0] valid_count;

  modport source (
    output valid, line_value, sample_value, valid_count,
    input  ready
  );
  modport sink (
    input  valid, line_value, sample_value, valid_count,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/dmi_cfg.sv
// Configuration registers and effective map sizes.
`default_nettype none

module dmi_cfg
  import dmi_pkg::*;
#(
  parameter int unsigned MAX_OUT_LINES   = 256,
  parameter int unsigned MAX_OUT_SAMPLES = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  logic [SIZE_W-1:0]       lines_q, samples_q;
  logic                    fill_q;
  logic signed [OFS_W-1:0] sample_ofs_q, line_ofs_q;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q      <= SIZE_W'(256);
      samples_q    <= SIZE_W'(256);
      fill_q       <= 1'b0;
      sample_ofs_q <= '0;
      line_ofs_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OUT_LINES:   lines_q      <= cfg_wdata_i[SIZE_W-1:0];
        CFG_OUT_SAMPLES: samples_q    <= cfg_wdata_i[SIZE_W-1:0];
        CFG_FILL_EN:     fill_q       <= cfg_wdata_i[0];
        CFG_SAMPLE_OFS:  sample_ofs_q <= $signed(cfg_wdata_i[OFS_W-1:0]);
        CFG_LINE_OFS:    line_ofs_q   <= $signed(cfg_wdata_i[OFS_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sizes are clamped to the range 1 .. maximum.
  always_comb begin
    dim_t lines_ext, samples_ext;
    lines_ext   = dim_t'(lines_q);
    samples_ext = dim_t'(samples_q);
    if (lines_q == '0) begin
      cfg_o.lines = dim_t'(1);
    end else if (lines_ext > dim_t'(MAX_OUT_LINES)) begin
      cfg_o.lines = dim_t'(MAX_OUT_LINES);
    end else begin
      cfg_o.lines = lines_ext;
    end
    if (samples_q == '0) begin
      cfg_o.samples = dim_t'(1);
    end else if (samples_ext > dim_t'(MAX_OUT_SAMPLES)) begin
      cfg_o.samples = dim_t'(MAX_OUT_SAMPLES);
    end else begin
      cfg_o.samples = samples_ext;
    end
    cfg_o.fill_en    = fill_q;
    cfg_o.sample_ofs = sample_ofs_q;
    cfg_o.line_ofs   = line_ofs_q;
  end

endmodule

`default_nettype wire

### hw/rtl/dmi_store.sv
// Output map store: one write port, one registered read port.
`default_nettype none

module dmi_store
  import dmi_pkg::*;
#(
  parameter int unsigned AW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/disparity_map_inverter.sv
// Top level of the disparity map inverter: control, pixel scatter and read-back.
//
// A pixel item that passes its bounds check writes its entry of the output map
// store directly when it is taken. A read item goes through ST_READ while the
// registered store read completes, and its result then waits in an output register.
// A start item, and likewise reset, runs a clearing pass over the store that
// rewrites one entry per cycle over all 2**(clog2(MAX_OUT_LINES) + clog2(MAX_OUT_SAMPLES))
// entries, 65536 with the default sizes, during which no item is accepted.
// Configuration writes are taken at any time but belong to idle periods.
`default_nettype none

module disparity_map_inverter
  import dmi_pkg::*;
#(
  parameter int unsigned MAX_OUT_LINES   = 256,
  parameter int unsigned MAX_OUT_SAMPLES = 256,
  parameter int unsigned MAX_SRC_DIM     = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dmi_in_if.sink                     in_i,
  dmi_out_if.source                  out_o
);

  localparam int unsigned LA_W = $clog2(MAX_OUT_LINES);
  localparam int unsigned SA_W = $clog2(MAX_OUT_SAMPLES);
  localparam int unsigned AW   = LA_W + SA_W;
  localparam int unsigned SRC_CMP_W = 17;

  cfg_t cfg;

  dmi_cfg #(
    .MAX_OUT_LINES  (MAX_OUT_LINES),
    .MAX_OUT_SAMPLES(MAX_OUT_SAMPLES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  state_e           state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] line_q, line_d, sample_q, sample_d;
  logic [CNT_W-1:0] count_q, count_d;
  rd_req_t          req_q, req_d;

  logic          accept;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  dmi_store #(.AW(AW)) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Pixel decode: round both disparities to 0-based indexes and check bounds.
  logic [SRC_W-1:0]  li, si;
  logic [DISP_W-1:0] ld_m8, sd_m8;
  logic              pix_ok;
  always_comb begin
    ld_m8 = in_i.line_disp - DISP_W'(8);
    sd_m8 = in_i.sample_disp - DISP_W'(8);
    li = (in_i.line_disp < DISP_W'(8)) ? '0 : ld_m8[DISP_W-1:4];
    si = (in_i.sample_disp < DISP_W'(8)) ? '0 : sd_m8[DISP_W-1:4];
    pix_ok = (SRC_CMP_W'(in_i.src_line) < SRC_CMP_W'(MAX_SRC_DIM))
          && (SRC_CMP_W'(in_i.src_sample) < SRC_CMP_W'(MAX_SRC_DIM))
          && !((in_i.line_disp == '0) && (in_i.sample_disp == '0))
          && (li != '0) && (si != '0)
          && ((dim_t'(li) + dim_t'(1)) < cfg.lines)
          && ((dim_t'(si) + dim_t'(1)) < cfg.samples);
  end

  // Read decode: map bounds and the fill defaults for an unwritten entry.
  logic [SRC_W-1:0]        rl_ext, rs_ext;
  logic signed [SRC_W-1:0] fl_diff, fs_diff;
  rd_req_t                 req_new;
  always_comb begin
    rl_ext  = SRC_W'(in_i.read_line);
    rs_ext  = SRC_W'(in_i.read_sample);
    fl_diff = $signed(rs_ext) - SRC_W'(cfg.sample_ofs);
    fs_diff = $signed(rl_ext) - SRC_W'(cfg.line_ofs);
    req_new.in_map  = (dim_t'(in_i.read_line) < cfg.lines)
                   && (dim_t'(in_i.read_sample) < cfg.samples);
    req_new.fill_en = cfg.fill_en;
    if (fl_diff[SRC_W-1]) begin
      req_new.fill_line = '0;
    end else if (dim_t'(fl_diff) >= cfg.lines) begin
      req_new.fill_line = VAL_W'(cfg.lines - dim_t'(1));
    end else begin
      req_new.fill_line = VAL_W'(fl_diff);
    end
    if (fs_diff[SRC_W-1]) begin
      req_new.fill_sample = '0;
    end else if (dim_t'(fs_diff) >= cfg.samples) begin
      req_new.fill_sample = VAL_W'(cfg.samples - dim_t'(1));
    end else begin
      req_new.fill_sample = VAL_W'(fs_diff);
    end
  end

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // Next state, store access and result formation.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    line_d      = line_q;
    sample_d    = sample_q;
    count_d     = count_q;
    req_d       = req_q;
    mem_we      = 1'b0;
    mem_waddr   = {li[LA_W-1:0], si[SA_W-1:0]};
    mem_wdata   = '{mark: 1'b1,
                    line_val: VAL_W'(in_i.src_line) + VAL_W'(1),
                    sample_val: VAL_W'(in_i.src_sample) + VAL_W'(1)};
    mem_re      = 1'b0;
    mem_raddr   = {rl_ext[LA_W-1:0], rs_ext[SA_W-1:0]};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.kind)
            KIND_START: begin
              cnt_d   = '0;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            KIND_PIXEL: begin
              if (pix_ok) begin
                mem_we = 1'b1;
                if (cnt_q != CNT_MAX) begin
                  cnt_d = cnt_q + CNT_W'(1);
                end
              end
            end
            KIND_READ: begin
              mem_re  = 1'b1;
              req_d   = req_new;
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (!req_q.in_map) begin
          line_d   = '0;
          sample_d = '0;
        end else if (mem_rdata.mark) begin
          line_d   = mem_rdata.line_val;
          sample_d = mem_rdata.sample_val;
        end else if (req_q.fill_en) begin
          line_d   = req_q.fill_line;
          sample_d = req_q.fill_sample;
        end else begin
          line_d   = '0;
          sample_d = '0;
        end
        count_d     = cnt_q;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    line_q   <= line_d;
    sample_q <= sample_d;
    count_q  <= count_d;
    req_q    <= req_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.line_value   = line_q;
  assign out_o.sample_value = sample_q;
  assign out_o.valid_count  = count_q;

  // No item is taken while the clearing pass runs.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_i.ready)
    else $error("item accepted during clearing pass");

  // A new result only follows a store read.
  a_result_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == ST_READ))
    else $error("result appeared without a store read");

  // The output register is free when a read completes.
  a_slot_free_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !out_valid_q)
    else $error("read completed into a full output register");

  // The count only falls at a start item.
  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE || !accept || in_i.kind != KIND_START) |=> cnt_q >= $past(cnt_q))
    else $error("valid count fell without a start item");

endmodule

`default_nettype wire

### tb/sv/disparity_map_inverter_test.sv
// Self-checking testbench of the disparity map inverter: directed and random frames.
`timescale 1ns / 100ps

module disparity_map_inverter_test;
  import dmi_pkg::*;

  localparam int MAP_LINES    = 256;
  localparam int MAP_SAMPLES  = 256;
  localparam int MAP_DEPTH    = MAP_LINES * MAP_SAMPLES;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 500;
  localparam int RECENT_DEPTH = 16;
  // Seven clearing passes over the whole store dominate; items and stalls add little.
  localparam int unsigned LIMIT_CYCLES = 3_000_000;

  // Codes outside the package lists: an item kind the block ignores and a
  // register index past the last register.
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SRC_W-1:0]  src_line;
    logic [SRC_W-1:0]  src_sample;
    logic [DISP_W-1:0] line_disp;
    logic [DISP_W-1:0] sample_disp;
    logic [RD_W-1:0]   read_line;
    logic [RD_W-1:0]   read_sample;
  } map_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] line_value;
    logic [VAL_W-1:0] sample_value;
    logic [CNT_W-1:0] valid_count;
  } map_read_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dmi_in_if  pix_if ();
  dmi_out_if res_if ();

  disparity_map_inverter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (pix_if),
    .out_o       (res_if)
  );

  // Predicted map: an entry counts as written when its tag equals the current frame.
  int unsigned      mark_tag [MAP_DEPTH];
  int unsigned      frame_tag = 1;
  logic [VAL_W-1:0] line_band [MAP_DEPTH];
  logic [VAL_W-1:0] sample_band [MAP_DEPTH];
  logic [CNT_W-1:0] pixel_total = '0;

  // Predicted register contents.
  logic [SIZE_W-1:0]       cfg_lines   = 9'd256;
  logic [SIZE_W-1:0]       cfg_samples = 9'd256;
  logic                    cfg_fill    = 1'b0;
  logic signed [OFS_W-1:0] cfg_sofs    = '0;
  logic signed [OFS_W-1:0] cfg_lofs    = '0;

  map_read_t   pending_reads [$];
  map_read_t   oldest_read;
  int          errors = 0;
  bit          steady = 1'b0;
  int          hold_req = 0;
  int          hold_left = 0;
  int unsigned cycle_count = 0;

  // Recently scattered entries, so that reads hit written entries often.
  int rec_line [RECENT_DEPTH];
  int rec_sample [RECENT_DEPTH];
  int rec_next = 0;

  always #CLK_HALF clk_i = ~clk_i;

  // Effective map sizes: a size below one acts as one, above the store as the store.
  function automatic int map_lines();
    if (cfg_lines == 0) return 1;
    if (cfg_lines > MAP_LINES) return MAP_LINES;
    return int'(cfg_lines);
  endfunction

  function automatic int map_samples();
    if (cfg_samples == 0) return 1;
    if (cfg_samples > MAP_SAMPLES) return MAP_SAMPLES;
    return int'(cfg_samples);
  endfunction

  // Rounds a 1-based Q12.4 disparity to a 0-based index.
  function automatic int disp_index(input logic [DISP_W-1:0] raw);
    if (raw < 16'd8) return 0;
    return int'((raw - 16'd8) >> 4);
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Applies one accepted item to the predicted map and queues the read result.
  function automatic void predict_map_item(input map_item_t it);
    int nlo, nso, li, si, rl, rs, idx;
    map_read_t res;
    nlo = map_lines();
    nso = map_samples();
    case (it.kind)
      KIND_START: begin
        frame_tag++;
        pixel_total = '0;
      end
      KIND_PIXEL: begin
        li = disp_index(it.line_disp);
        si = disp_index(it.sample_disp);
        // Zero disparities give index zero and fall out here as well.
        if (li >= 1 && si >= 1 && li <= nlo - 2 && si <= nso - 2) begin
          idx = li * MAP_SAMPLES + si;
          mark_tag[idx] = frame_tag;
          line_band[idx] = {1'b0, it.src_line} + 13'd1;
          sample_band[idx] = {1'b0, it.src_sample} + 13'd1;
          if (pixel_total != CNT_MAX) pixel_total++;
        end
      end
      KIND_READ: begin
        rl = it.read_line;
        rs = it.read_sample;
        res = '0;
        res.valid_count = pixel_total;
        // Reads outside the map return zeros in both bands.
        if (rl < nlo && rs < nso) begin
          idx = rl * MAP_SAMPLES + rs;
          if (mark_tag[idx] == frame_tag) begin
            res.line_value = line_band[idx];
            res.sample_value = sample_band[idx];
          end else if (cfg_fill) begin
            res.line_value = VAL_W'(clamp_to(rs - int'(cfg_sofs), nlo - 1));
            res.sample_value = VAL_W'(clamp_to(rl - int'(cfg_lofs), nso - 1));
          end
        end
        pending_reads.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // Offers one item, with random gaps unless in a steady stretch; valid stays high after.
  task automatic send_item(input logic [KIND_W-1:0] kind, input int sl, input int ss,
                           input int ld, input int sd, input int rl, input int rs);
    map_item_t it;
    it.kind = kind;
    it.src_line = SRC_W'(sl);
    it.src_sample = SRC_W'(ss);
    it.line_disp = DISP_W'(ld);
    it.sample_disp = DISP_W'(sd);
    it.read_line = RD_W'(rl);
    it.read_sample = RD_W'(rs);
    while (!steady && $urandom_range(99) < 14) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.kind <= it.kind;
    pix_if.src_line <= it.src_line;
    pix_if.src_sample <= it.src_sample;
    pix_if.line_disp <= it.line_disp;
    pix_if.sample_disp <= it.sample_disp;
    pix_if.read_line <= it.read_line;
    pix_if.read_sample <= it.read_sample;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    predict_map_item(it);
  endtask

  // Unused fields of each kind carry random values.
  task automatic send_pixel(input int sl, input int ss, input int ld, input int sd);
    send_item(KIND_PIXEL, sl, ss, ld, sd, $urandom_range(255), $urandom_range(255));
  endtask

  task automatic send_read(input int rl, input int rs);
    send_item(KIND_READ, $urandom_range(4095), $urandom_range(4095),
              $urandom_range(16'hFFFF), $urandom_range(16'hFFFF), rl, rs);
  endtask

  task automatic send_ctrl(input logic [KIND_W-1:0] kind);
    send_item(kind, $urandom_range(4095), $urandom_range(4095), $urandom_range(16'hFFFF),
              $urandom_range(16'hFFFF), $urandom_range(255), $urandom_range(255));
  endtask

  // Ends a stretch with a read, so the block is idle once every result is back.
  task automatic settle_map();
    send_read($urandom_range(255), $urandom_range(255));
    pix_if.valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      CFG_OUT_LINES:   cfg_lines = data[SIZE_W-1:0];
      CFG_OUT_SAMPLES: cfg_samples = data[SIZE_W-1:0];
      CFG_FILL_EN:     cfg_fill = data[0];
      CFG_SAMPLE_OFS:  cfg_sofs = data;
      CFG_LINE_OFS:    cfg_lofs = data;
      default: ;
    endcase
  endtask

  // Writes every register; a write to the spare index goes first and must be ignored.
  task automatic program_map(input int lines, input int samples, input int fill,
                             input int sofs, input int lofs);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_OUT_LINES, CFG_DATA_W'(lines));
    write_reg(CFG_OUT_SAMPLES, CFG_DATA_W'(samples));
    write_reg(CFG_FILL_EN, CFG_DATA_W'(fill));
    write_reg(CFG_SAMPLE_OFS, CFG_DATA_W'(sofs));
    write_reg(CFG_LINE_OFS, CFG_DATA_W'(lofs));
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed pixels and reads of recent entries, with some noise.
  task automatic send_random_item();
    int nlo, nso, pick, li, si, k;
    nlo = map_lines();
    nso = map_samples();
    pick = $urandom_range(99);
    if (pick < 3) begin
      send_ctrl(KIND_UNUSED);
    end else if (pick < 10) begin
      send_pixel($urandom_range(4095), $urandom_range(4095),
                 $urandom_range(1) ? $urandom_range(16'hFFFF) : $urandom_range(23),
                 $urandom_range(1) ? $urandom_range(16'hFFFF) : $urandom_range(23));
    end else if (pick < 55 && nlo >= 3 && nso >= 3) begin
      li = $urandom_range(nlo - 2, 1);
      si = $urandom_range(nso - 2, 1);
      send_pixel($urandom_range(4095), $urandom_range(4095),
                 li * 16 + 8 + $urandom_range(15), si * 16 + 8 + $urandom_range(15));
      rec_line[rec_next] = li;
      rec_sample[rec_next] = si;
      rec_next = (rec_next + 1) % RECENT_DEPTH;
    end else if (pick < 75) begin
      k = $urandom_range(RECENT_DEPTH - 1);
      send_read(rec_line[k], rec_sample[k]);
    end else if (pick < 92) begin
      send_read($urandom_range(nlo - 1), $urandom_range(nso - 1));
    end else begin
      send_read($urandom_range(255), $urandom_range(255));
    end
  endtask

  // Default map: skipped pixels, rounding limits, overwrite and extreme positions.
  task automatic test_directed_scatter();
    send_read(0, 0);
    send_pixel(5, 5, 0, 0);
    send_pixel(3, 3, 7, 24);
    send_pixel(0, 0, 24, 24);
    send_pixel(4095, 4095, 4087, 4087);
    send_pixel(9, 9, 4088, 40);
    send_pixel(1, 2, 16'hFFFF, 16'hFFFF);
    send_ctrl(KIND_UNUSED);
    send_read(1, 1);
    send_read(254, 254);
    send_read(255, 255);
    send_pixel(100, 200, 24, 24);
    send_read(1, 1);
    settle_map();
  endtask

  // Fill defaults with clamping at both ends, and sizes out of range.
  task automatic test_fill_defaults();
    program_map(5, 7, 1, -256, 256);
    send_read(0, 0);
    send_read(4, 6);
    send_read(5, 0);
    send_read(1, 1);
    settle_map();
    program_map(0, 0, 1, 511, -512);
    send_read(0, 0);
    send_read(0, 1);
    settle_map();
    program_map(256, 256, 1, 0, 0);
    send_read(255, 255);
    settle_map();
  endtask

  // A start item clears every mark and the count but keeps the map usable.
  task automatic test_frame_restart();
    send_ctrl(KIND_START);
    send_read(1, 1);
    send_pixel(7, 9, 24, 40);
    send_read(1, 2);
    send_read(254, 254);
    settle_map();
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    program_map(64, 64, 1, 3, -3);
    @(negedge clk_i) hold_req = HOLD_CYCLES;
    @(posedge clk_i);
    repeat (60) send_random_item();
    settle_map();
  endtask

  // Frames under several settings; each pauses halfway until every result is back.
  task automatic test_random_frames();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_map(256, 256, 0, 0, 0);
        1: program_map(511, 0, 1, $urandom_range(1023), $urandom_range(1023));
        2: program_map($urandom_range(40, 3), $urandom_range(40, 3), 1,
                       $urandom_range(1023), $urandom_range(1023));
        3: program_map(3, 3, 1, -256, 256);
        4: program_map($urandom_range(511, 257), $urandom_range(256, 1),
                       $urandom_range(1), 256, -256);
        default: program_map($urandom_range(64, 3), $urandom_range(64, 3), 1, -512, 511);
      endcase
      // The last frame runs with no idling on either side.
      steady = (ph == 5);
      // The frame after the smallest map keeps its marks under a larger map.
      if (ph != 4) send_ctrl(KIND_START);
      repeat (ph == 1 ? 50 : 180) send_random_item();
      settle_map();
      repeat (ph == 1 ? 50 : 180) send_random_item();
      settle_map();
    end
    steady = 1'b0;
  endtask

  // Result side: check each accepted result, then choose ready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_reads.size() == 0) begin
        $error("read result with none expected: line_value %0d sample_value %0d",
               res_if.line_value, res_if.sample_value);
        errors++;
      end else begin
        oldest_read = pending_reads.pop_front();
        if (res_if.line_value !== oldest_read.line_value) begin
          $error("line_value: expected %0d, got %0d", oldest_read.line_value,
                 res_if.line_value);
          errors++;
        end
        if (res_if.sample_value !== oldest_read.sample_value) begin
          $error("sample_value: expected %0d, got %0d", oldest_read.sample_value,
                 res_if.sample_value);
          errors++;
        end
        if (res_if.valid_count !== oldest_read.valid_count) begin
          $error("valid_count: expected %0d, got %0d", oldest_read.valid_count,
                 res_if.valid_count);
          errors++;
        end
      end
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** disparity_map_inverter: FAILED **");
      $finish;
    end
  end

  initial begin
    pix_if.valid = 1'b0;
    pix_if.kind = KIND_START;
    pix_if.src_line = '0;
    pix_if.src_sample = '0;
    pix_if.line_disp = '0;
    pix_if.sample_disp = '0;
    pix_if.read_line = '0;
    pix_if.read_sample = '0;
    res_if.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_scatter();
    test_fill_defaults();
    test_frame_restart();
    test_backpressure();
    test_random_frames();

    repeat (8) @(posedge clk_i);
    if (pending_reads.size() != 0) begin
      $error("%0d read results never arrived", pending_reads.size());
      errors++;
    end
    if (errors == 0) begin
      $display("** disparity_map_inverter: PASSED **");
    end else begin
      $display("** disparity_map_inverter: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/dmi_pkg.sv
hw/rtl/dmi_if.sv
hw/rtl/dmi_cfg.sv
hw/rtl/dmi_store.sv
hw/rtl/disparity_map_inverter.sv
tb/sv/disparity_map_inverter_test.sv
